/* rtl/core/first_fit_extent_allocator_macros.svh */
// Assertion macros shared by the allocator checkers.
// Needs nothing else; include by bare file name.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFEA_ASSERT_IMP(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("ffea: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFEA_ASSERT_NXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("ffea: next-cycle check failed");

`endif

/* rtl/core/ffea_pkg.sv */
// Package for the first-fit extent allocator: codes, command and status types.
// Used by the controller, datapath, top level and checkers; depends on nothing.
package ffea_pkg;

  localparam int unsigned CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_HEAP_BASE       = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HEAP_LIMIT      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_PAGE_BYTES      = 3'd2;
  localparam logic [CFG_IW-1:0] REG_GROW_MIN        = 3'd3;
  localparam logic [CFG_IW-1:0] REG_GIVE_BACK       = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MIN_BLOCK       = 3'd5;
  localparam logic [CFG_IW-1:0] REG_LARGE_THRESHOLD = 3'd6;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_LARGE = 3'd2;
  localparam logic [2:0] ST_OOM   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  localparam logic [31:0] RST_HEAP_LIMIT = 32'd268435456;
  localparam logic [16:0] RST_PAGE_BYTES = 17'd4096;
  localparam logic [31:0] RST_GROW_MIN   = 32'd33554432;
  localparam logic [31:0] RST_GIVE_BACK  = 32'd33554432;
  localparam logic [12:0] RST_MIN_BLOCK  = 13'd32;
  localparam logic [31:0] RST_LARGE_THR  = 32'd1048576;
  localparam logic [12:0] MIN_BLOCK_FLOOR = 13'd16;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ROUND, OP_SCAN_START, OP_SCAN_RD, OP_SCAN_NEXT,
    OP_SPLIT, OP_TAKE, OP_DROP_RD, OP_DROP_WR, OP_DROP_END, OP_DIV, OP_PAGES,
    OP_GROW_PUT, OP_GROW_COMMIT, OP_PUT_INIT, OP_PUT_RD, OP_PUT_LEFT,
    OP_PUT_STOP, OP_MERGE_BOTH, OP_MERGE_LEFT, OP_MERGE_RIGHT, OP_SHUP_START,
    OP_SHUP_RD, OP_SHUP_WR, OP_INSERT, OP_TAIL_RD, OP_TAIL_CUT, OP_TAIL_DROP,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       st_we;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero;
    logic outside;
    logic ns_ge_need;
    logic over_thr;
    logic idx_lt_count;
    logic fit;
    logic rest_ge_mb;
    logic le_a;
    logic div_last;
    logic grow_bad;
    logic tail_ge_mb;
    logic left;
    logic right;
    logic full;
    logic drop_more;
    logic shup_more;
    logic tail_hit;
    logic tail_base;
    logic tail_gt;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/core/ffea_if.sv */
// Request and response channel interfaces of the allocator.
// Stand-alone; no package needed.
interface ffea_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] req_size;
  logic [31:0] free_address;
  logic [31:0] free_length;

  modport source (output valid, req_type, req_size, free_address, free_length,
                  input ready);
  modport sink (input valid, req_type, req_size, free_address, free_length,
                output ready);
endinterface

interface ffea_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] grant_address;
  logic [31:0] grant_length;
  logic [31:0] heap_end_now;

  modport source (output valid, status, grant_address, grant_length, heap_end_now,
                  input ready);
  modport sink (input valid, status, grant_address, grant_length, heap_end_now,
                output ready);
endinterface

/* rtl/core/ffea_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffea_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/ffea_ctrl.sv */
// Sequencing state machine of the allocator: issues one datapath command a cycle, holding while the result is stalled.
// Depends on ffea_pkg.
module ffea_ctrl import ffea_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CHK      = 5'd1;
  localparam logic [4:0] S_ROUND    = 5'd2;
  localparam logic [4:0] S_LARGE    = 5'd3;
  localparam logic [4:0] S_SCAN_RD  = 5'd4;
  localparam logic [4:0] S_SCAN_CK  = 5'd5;
  localparam logic [4:0] S_DROP     = 5'd6;
  localparam logic [4:0] S_DROP_WR  = 5'd7;
  localparam logic [4:0] S_DIV      = 5'd8;
  localparam logic [4:0] S_PAGES    = 5'd9;
  localparam logic [4:0] S_GROW_CK  = 5'd10;
  localparam logic [4:0] S_PUT_INIT = 5'd11;
  localparam logic [4:0] S_PUT_RD   = 5'd12;
  localparam logic [4:0] S_PUT_CK   = 5'd13;
  localparam logic [4:0] S_PUT_DEC  = 5'd14;
  localparam logic [4:0] S_SHUP     = 5'd15;
  localparam logic [4:0] S_SHUP_WR  = 5'd16;
  localparam logic [4:0] S_PUT_OK   = 5'd17;
  localparam logic [4:0] S_TAIL_RD  = 5'd18;
  localparam logic [4:0] S_TAIL_CK  = 5'd19;
  localparam logic [4:0] S_PUB      = 5'd20;

  logic [4:0] state_q, state_d;
  // Set when a removal was started by a two-sided merge and must then go on to the put-done state.
  logic       ret_q, ret_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cmd_o     = '{op: OP_NONE, st_we: 1'b0, st: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.zero) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_ZERO;
          state_d     = S_PUB;
        end else if (sts_i.is_free) begin
          state_d = sts_i.outside ? S_PUB : S_PUT_INIT;
        end else begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (sts_i.ns_ge_need) begin
          state_d = S_LARGE;
        end else begin
          cmd_o.op = OP_ROUND;
        end
      end
      S_LARGE: begin
        if (sts_i.over_thr) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_LARGE;
          state_d     = S_PUB;
        end else begin
          cmd_o.op = OP_SCAN_START;
          state_d  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.idx_lt_count) begin
          cmd_o.op = OP_SCAN_RD;
          state_d  = S_SCAN_CK;
        end else begin
          state_d = S_DIV;
        end
      end
      S_SCAN_CK: begin
        if (sts_i.fit && sts_i.rest_ge_mb) begin
          cmd_o.op = OP_SPLIT;
          state_d  = S_PUB;
        end else if (sts_i.fit) begin
          cmd_o.op = OP_TAKE;
          ret_d    = 1'b0;
          state_d  = S_DROP;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_SCAN_RD;
        end
      end
      S_DROP: begin
        if (sts_i.drop_more) begin
          cmd_o.op = OP_DROP_RD;
          state_d  = S_DROP_WR;
        end else begin
          cmd_o.op = OP_DROP_END;
          state_d  = ret_q ? S_PUT_OK : S_PUB;
        end
      end
      S_DROP_WR: begin
        cmd_o.op = OP_DROP_WR;
        state_d  = S_DROP;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (sts_i.div_last) begin
          state_d = S_PAGES;
        end
      end
      S_PAGES: begin
        cmd_o.op = OP_PAGES;
        state_d  = S_GROW_CK;
      end
      S_GROW_CK: begin
        if (sts_i.grow_bad) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_OOM;
          state_d     = S_PUB;
        end else if (sts_i.tail_ge_mb) begin
          cmd_o.op = OP_GROW_PUT;
          state_d  = S_PUT_INIT;
        end else begin
          cmd_o.op = OP_GROW_COMMIT;
          state_d  = S_PUB;
        end
      end
      S_PUT_INIT: begin
        cmd_o.op = OP_PUT_INIT;
        state_d  = S_PUT_RD;
      end
      S_PUT_RD: begin
        if (sts_i.idx_lt_count) begin
          cmd_o.op = OP_PUT_RD;
          state_d  = S_PUT_CK;
        end else begin
          cmd_o.op = OP_PUT_STOP;
          state_d  = S_PUT_DEC;
        end
      end
      S_PUT_CK: begin
        if (sts_i.le_a) begin
          cmd_o.op = OP_PUT_LEFT;
          state_d  = S_PUT_RD;
        end else begin
          cmd_o.op = OP_PUT_STOP;
          state_d  = S_PUT_DEC;
        end
      end
      S_PUT_DEC: begin
        if (sts_i.left && sts_i.right) begin
          cmd_o.op = OP_MERGE_BOTH;
          ret_d    = 1'b1;
          state_d  = S_DROP;
        end else if (sts_i.left) begin
          cmd_o.op = OP_MERGE_LEFT;
          state_d  = S_PUT_OK;
        end else if (sts_i.right) begin
          cmd_o.op = OP_MERGE_RIGHT;
          state_d  = S_PUT_OK;
        end else if (sts_i.full) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_FULL;
          state_d     = S_PUB;
        end else begin
          cmd_o.op = OP_SHUP_START;
          state_d  = S_SHUP;
        end
      end
      S_SHUP: begin
        if (sts_i.shup_more) begin
          cmd_o.op = OP_SHUP_RD;
          state_d  = S_SHUP_WR;
        end else begin
          cmd_o.op = OP_INSERT;
          state_d  = S_PUT_OK;
        end
      end
      S_SHUP_WR: begin
        cmd_o.op = OP_SHUP_WR;
        state_d  = S_SHUP;
      end
      S_PUT_OK: begin
        if (sts_i.is_free) begin
          state_d = S_TAIL_RD;
        end else begin
          cmd_o.op = OP_GROW_COMMIT;
          state_d  = S_PUB;
        end
      end
      S_TAIL_RD: begin
        cmd_o.op = OP_TAIL_RD;
        state_d  = S_TAIL_CK;
      end
      S_TAIL_CK: begin
        if (sts_i.tail_hit && !sts_i.tail_base) begin
          cmd_o.op = OP_TAIL_DROP;
        end else if (sts_i.tail_hit && sts_i.tail_gt) begin
          cmd_o.op = OP_TAIL_CUT;
        end
        state_d = S_PUB;
      end
      S_PUB: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_PUBLISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end
endmodule

/* rtl/core/ffea_dp.sv */
// Datapath of the allocator: registers, extent table RAM, compares and result register.
// Depends on ffea_pkg and ffea_ram.
module ffea_dp import ffea_pkg::*; #(
  parameter int unsigned MAX_EXTENTS  = 64,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              req_type_i,
  input  logic [31:0]       req_size_i,
  input  logic [31:0]       free_address_i,
  input  logic [31:0]       free_length_i,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  output logic [2:0]        rsp_status_o,
  output logic [31:0]       rsp_grant_address_o,
  output logic [31:0]       rsp_grant_length_o,
  output logic [31:0]       rsp_heap_end_now_o
);
  localparam int unsigned AW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

  logic [31:0] base_q, limit_q, grow_q, give_q, thr_q;
  logic [16:0] page_q;
  logic [12:0] minb_q;

  logic        type_q, zero_q;
  logic [33:0] need_q, ns_q, pages_q;
  logic [31:0] a_q, n_q, prev_s_q, prev_l_q, next_s_q, next_l_q;
  logic        has_prev_q, has_next_q;
  logic [CW-1:0] idx_q, j_q, pos_q, count_q;
  logic [16:0] rem_q;
  logic [4:0]  bit_q;
  logic [31:0] top_q, ga_q, gl_q;
  logic [2:0]  st_q;
  logic        out_valid_q;
  logic [2:0]  out_st_q;
  logic [31:0] out_ga_q, out_gl_q, out_top_q;

  logic [12:0] mb;
  logic [16:0] pg;
  logic [63:0] rdata;
  logic [31:0] r_s, r_l;
  logic [33:0] rest, pages0, tail_len;
  logic [16:0] rem_sh, rem_d;
  logic [31:0] ns_lo;
  logic [34:0] used_sum, end_sum;
  logic [CW-1:0] raddr, waddr;
  logic        we;
  logic [63:0] wdata;

  // A page size of zero acts as one; a minimum block below the floor acts as the floor.
  assign mb    = (minb_q < MIN_BLOCK_FLOOR) ? MIN_BLOCK_FLOOR : minb_q;
  assign pg    = (page_q == '0) ? 17'd1 : page_q;
  assign r_s   = rdata[63:32];
  assign r_l   = rdata[31:0];
  assign rest  = {2'b00, r_l} - ns_q;
  assign ns_lo = ns_q[31:0];

  // One bit of restoring division per cycle for the page remainder.
  assign rem_sh = {rem_q[15:0], ns_lo[~bit_q]};
  assign rem_d  = (rem_sh >= pg) ? (rem_sh - pg) : rem_sh;

  assign pages0   = {2'b00, ns_lo} - {17'd0, rem_q} + {17'd0, pg};
  assign tail_len = pages_q - ns_q;
  assign used_sum = {3'b000, top_q - base_q} + {1'b0, pages_q};
  assign end_sum  = {3'b000, top_q} + {1'b0, pages_q};

  always_comb begin
    sts_o.is_free      = type_q;
    sts_o.zero         = zero_q;
    sts_o.outside      = (a_q < base_q) || (({1'b0, a_q} + {1'b0, n_q}) > {1'b0, top_q});
    sts_o.ns_ge_need   = ns_q >= need_q;
    sts_o.over_thr     = ns_q >= {2'b00, thr_q};
    sts_o.idx_lt_count = idx_q < count_q;
    sts_o.fit          = {2'b00, r_l} >= ns_q;
    sts_o.rest_ge_mb   = rest >= {21'd0, mb};
    sts_o.le_a         = r_s <= a_q;
    sts_o.div_last     = bit_q == 5'd31;
    sts_o.grow_bad     = (top_q < base_q) || (used_sum > {3'b000, limit_q}) ||
                         (end_sum > {3'b000, 32'hFFFF_FFFF});
    sts_o.tail_ge_mb   = tail_len >= {21'd0, mb};
    sts_o.left         = has_prev_q && (({1'b0, prev_s_q} + {1'b0, prev_l_q}) == {1'b0, a_q});
    sts_o.right        = has_next_q && (({1'b0, a_q} + {1'b0, n_q}) == {1'b0, next_s_q});
    sts_o.full         = count_q >= CW'(MAX_EXTENTS);
    sts_o.drop_more    = ({1'b0, j_q} + 1'b1) < {1'b0, count_q};
    sts_o.shup_more    = j_q > pos_q;
    sts_o.tail_hit     = (({1'b0, r_s} + {1'b0, r_l}) == {1'b0, top_q}) && (r_l >= give_q);
    sts_o.tail_base    = r_s == base_q;
    sts_o.tail_gt      = r_l > give_q;
    sts_o.out_busy     = out_valid_q && !rsp_ready_i;
  end

  always_comb begin
    raddr = idx_q;
    waddr = idx_q;
    we    = 1'b0;
    wdata = rdata;
    case (cmd_i.op)
      OP_DROP_RD: raddr = j_q + 1'b1;
      OP_SHUP_RD: raddr = j_q - 1'b1;
      OP_TAIL_RD: raddr = count_q - 1'b1;
      OP_SPLIT: begin
        we    = 1'b1;
        wdata = {r_s + ns_lo, rest[31:0]};
      end
      OP_DROP_WR: begin
        we    = 1'b1;
        waddr = j_q;
      end
      OP_MERGE_BOTH: begin
        we    = 1'b1;
        waddr = pos_q - 1'b1;
        wdata = {prev_s_q, prev_l_q + n_q + next_l_q};
      end
      OP_MERGE_LEFT: begin
        we    = 1'b1;
        waddr = pos_q - 1'b1;
        wdata = {prev_s_q, prev_l_q + n_q};
      end
      OP_MERGE_RIGHT: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = {a_q, next_l_q + n_q};
      end
      OP_SHUP_WR: begin
        we    = 1'b1;
        waddr = j_q;
      end
      OP_INSERT: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = {a_q, n_q};
      end
      OP_TAIL_CUT: begin
        we    = 1'b1;
        waddr = count_q - 1'b1;
        wdata = {r_s, give_q};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ffea_ram #(
    .WIDTH(64),
    .DEPTH(MAX_EXTENTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr[AW-1:0]),
    .rdata_o(rdata)
  );

  // Control state: configuration, table fill count, heap top, result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      limit_q     <= RST_HEAP_LIMIT;
      page_q      <= RST_PAGE_BYTES;
      grow_q      <= RST_GROW_MIN;
      give_q      <= RST_GIVE_BACK;
      minb_q      <= RST_MIN_BLOCK;
      thr_q       <= RST_LARGE_THR;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_HEAP_BASE: begin
            base_q  <= cfg_data_i;
            count_q <= '0;
            top_q   <= cfg_data_i;
          end
          REG_HEAP_LIMIT:      limit_q <= cfg_data_i;
          REG_PAGE_BYTES:      page_q  <= cfg_data_i[16:0];
          REG_GROW_MIN:        grow_q  <= cfg_data_i;
          REG_GIVE_BACK:       give_q  <= cfg_data_i;
          REG_MIN_BLOCK:       minb_q  <= cfg_data_i[12:0];
          REG_LARGE_THRESHOLD: thr_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        OP_DROP_END:    count_q <= count_q - 1'b1;
        OP_INSERT:      count_q <= count_q + 1'b1;
        OP_GROW_COMMIT: top_q   <= top_q + pages_q[31:0];
        OP_TAIL_CUT:    top_q   <= r_s + give_q;
        OP_TAIL_DROP: begin
          count_q <= count_q - 1'b1;
          top_q   <= r_s;
        end
        default: begin
        end
      endcase
      if (cmd_i.op == OP_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.st_we) begin
      st_q <= cmd_i.st;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        type_q <= req_type_i;
        zero_q <= req_type_i ? (free_length_i == '0) : (req_size_i == '0);
        a_q    <= free_address_i;
        n_q    <= free_length_i;
        need_q <= {2'b00, req_size_i} + 34'(HEADER_BYTES);
        ns_q   <= {21'd0, mb};
        st_q   <= ST_OK;
        ga_q   <= '0;
        gl_q   <= '0;
      end
      OP_ROUND: ns_q <= {ns_q[32:0], 1'b0};
      OP_SCAN_START: begin
        idx_q <= '0;
        rem_q <= '0;
        bit_q <= '0;
      end
      OP_SCAN_NEXT: idx_q <= idx_q + 1'b1;
      OP_SPLIT: begin
        ga_q <= r_s;
        gl_q <= ns_lo;
      end
      OP_TAKE: begin
        ga_q <= r_s;
        gl_q <= r_l;
        j_q  <= idx_q;
      end
      OP_DROP_WR: j_q <= j_q + 1'b1;
      OP_DIV: begin
        rem_q <= rem_d;
        bit_q <= bit_q + 1'b1;
      end
      OP_PAGES: pages_q <= (pages0 < {2'b00, grow_q}) ? {2'b00, grow_q} : pages0;
      OP_GROW_PUT: begin
        a_q <= top_q + ns_lo;
        n_q <= tail_len[31:0];
      end
      OP_GROW_COMMIT: begin
        ga_q <= top_q;
        gl_q <= (tail_len >= {21'd0, mb}) ? ns_lo : pages_q[31:0];
      end
      OP_PUT_INIT: begin
        idx_q      <= '0;
        has_prev_q <= 1'b0;
      end
      OP_PUT_LEFT: begin
        prev_s_q   <= r_s;
        prev_l_q   <= r_l;
        has_prev_q <= 1'b1;
        idx_q      <= idx_q + 1'b1;
      end
      OP_PUT_STOP: begin
        next_s_q   <= r_s;
        next_l_q   <= r_l;
        has_next_q <= idx_q < count_q;
        pos_q      <= idx_q;
      end
      OP_MERGE_BOTH: j_q <= pos_q;
      OP_SHUP_START: j_q <= count_q;
      OP_SHUP_WR:    j_q <= j_q - 1'b1;
      OP_PUBLISH: begin
        out_st_q  <= st_q;
        out_ga_q  <= (st_q == ST_OK) ? ga_q : '0;
        out_gl_q  <= (st_q == ST_OK) ? gl_q : '0;
        out_top_q <= top_q;
      end
      default: begin
      end
    endcase
  end

  assign rsp_valid_o         = out_valid_q;
  assign rsp_status_o        = out_st_q;
  assign rsp_grant_address_o = out_ga_q;
  assign rsp_grant_length_o  = out_gl_q;
  assign rsp_heap_end_now_o  = out_top_q;
endmodule

/* rtl/core/first_fit_extent_allocator.sv */
// First-fit extent allocator, top level: controller, datapath and channels.
// One request at a time. An allocate rounds its size, scans the table for the first fit and
// takes or splits that entry; with no fit it grows the heap by whole pages and may insert the
// leftover tail as a new extent. A free inserts or merges its extent, then may give back the heap tail.
// The extent table has one write port and one read port; each scan step reads one entry.
// Reset (async, active low) empties the table and restores register defaults.
module first_fit_extent_allocator import ffea_pkg::*; #(
  parameter int unsigned MAX_EXTENTS  = 64,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffea_req_if.sink          req,
  ffea_rsp_if.source        rsp,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  ffea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req.valid),
    .req_ready_o(req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffea_dp #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .req_type_i         (req.req_type),
    .req_size_i         (req.req_size),
    .free_address_i     (req.free_address),
    .free_length_i      (req.free_length),
    .rsp_ready_i        (rsp.ready),
    .rsp_valid_o        (rsp.valid),
    .rsp_status_o       (rsp.status),
    .rsp_grant_address_o(rsp.grant_address),
    .rsp_grant_length_o (rsp.grant_length),
    .rsp_heap_end_now_o (rsp.heap_end_now)
  );
endmodule

/* rtl/core/ffea_checker.sv */
// Port-level checks for the allocator, bound to the top level.
// Depends on ffea_pkg and first_fit_extent_allocator_macros.svh.
`include "first_fit_extent_allocator_macros.svh"

module ffea_checker import ffea_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [31:0] rsp_grant_address_i,
  input logic [31:0] rsp_grant_length_i,
  input logic [31:0] rsp_heap_end_now_i
);
  // A stalled result stays valid and keeps its status and heap end.
  `FFEA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
    rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_heap_end_now_i))
  // Only defined status codes are returned.
  `FFEA_ASSERT_IMP(a_status_code, clk_i, rst_ni, rsp_valid_i, rsp_status_i <= ST_FULL)
  // A failed request grants nothing.
  `FFEA_ASSERT_IMP(a_fail_no_grant, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != ST_OK),
    (rsp_grant_address_i == '0) && (rsp_grant_length_i == '0))
  // One request in flight: accepting a request closes the request channel.
  `FFEA_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i,
    !req_ready_i)
endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req.valid),
  .req_ready_i        (req.ready),
  .rsp_valid_i        (rsp.valid),
  .rsp_ready_i        (rsp.ready),
  .rsp_status_i       (rsp.status),
  .rsp_grant_address_i(rsp.grant_address),
  .rsp_grant_length_i (rsp.grant_length),
  .rsp_heap_end_now_i (rsp.heap_end_now)
);

/* test/first_fit_extent_allocator_checker.sv */
// Checker for the first-fit extent allocator: watches the request, response and
// register ports, predicts each response and compares it. Needs ffea_pkg and ffea_if.
module first_fit_extent_allocator_checker import ffea_pkg::*; #(
  parameter int unsigned MAX_EXTENTS  = 64,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffea_req_if               req,
  ffea_rsp_if               rsp,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_ALLOC = 1'b0;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] top;
  } grant_t;

  grant_t grant_q[$];
  int     fails;

  logic [31:0] base_r, limit_r, grow_r, give_r, large_r;
  logic [16:0] page_r;
  logic [12:0] minblk_r;
  logic [31:0] ext_start[MAX_EXTENTS];
  logic [31:0] ext_len[MAX_EXTENTS];
  int          ext_cnt;
  logic [31:0] top_r;

  assign fail_count_o = fails;
  assign pending_o    = grant_q.size();

  function void drop_extent(int i);
    for (int j = i; j < ext_cnt - 1; j++) begin
      ext_start[j] = ext_start[j+1];
      ext_len[j]   = ext_len[j+1];
    end
    ext_cnt--;
  endfunction

  // Inserts a free extent in address order, merging with either neighbor or both where they touch.
  function bit insert_extent(logic [31:0] a, logic [31:0] n);
    int pos;
    bit left, right;
    pos = 0;
    while (pos < ext_cnt && ext_start[pos] <= a) pos++;
    left  = pos > 0 && {1'b0, ext_start[pos-1]} + ext_len[pos-1] == {1'b0, a};
    right = pos < ext_cnt && {1'b0, a} + n == {1'b0, ext_start[pos]};
    if (left && right) begin
      ext_len[pos-1] = ext_len[pos-1] + n + ext_len[pos];
      drop_extent(pos);
    end else if (left) begin
      ext_len[pos-1] = ext_len[pos-1] + n;
    end else if (right) begin
      ext_start[pos] = a;
      ext_len[pos]   = ext_len[pos] + n;
    end else begin
      if (ext_cnt >= MAX_EXTENTS) return 0;
      for (int j = ext_cnt; j > pos; j--) begin
        ext_start[j] = ext_start[j-1];
        ext_len[j]   = ext_len[j-1];
      end
      ext_start[pos] = a;
      ext_len[pos]   = n;
      ext_cnt++;
    end
    return 1;
  endfunction

  function void predict_alloc(logic [31:0] size, output grant_t g);
    logic [63:0] mb, pg, need, ns, pages;
    g = '{ST_OK, 32'd0, 32'd0, 32'd0};
    mb = (minblk_r < MIN_BLOCK_FLOOR) ? 64'd16 : 64'(minblk_r);
    pg = (page_r == 0) ? 64'd1 : 64'(page_r);
    if (size == 0) begin
      g.status = ST_ZERO;
      return;
    end
    need = 64'(size) + HEADER_BYTES;
    ns = mb;
    while (ns < need) ns = ns << 1;
    if (ns >= 64'(large_r)) begin
      g.status = ST_LARGE;
      return;
    end
    for (int i = 0; i < ext_cnt; i++) begin
      if (64'(ext_len[i]) >= ns) begin
        g.addr = ext_start[i];
        if (64'(ext_len[i]) - ns >= mb) begin
          g.len = ns[31:0];
          ext_start[i] = ext_start[i] + ns[31:0];
          ext_len[i]   = ext_len[i] - ns[31:0];
        end else begin
          g.len = ext_len[i];
          drop_extent(i);
        end
        return;
      end
    end
    pages = (ns / pg + 1) * pg;
    if (pages < 64'(grow_r)) pages = 64'(grow_r);
    if (top_r < base_r || 64'(top_r - base_r) + pages > 64'(limit_r) ||
        64'(top_r) + pages > 64'hFFFF_FFFF) begin
      g.status = ST_OOM;
      return;
    end
    if (pages - ns >= mb) begin
      if (!insert_extent(top_r + ns[31:0], 32'(pages - ns))) begin
        g.status = ST_FULL;
        return;
      end
      g.len = ns[31:0];
    end else begin
      g.len = pages[31:0];
    end
    g.addr = top_r;
    top_r  = top_r + pages[31:0];
  endfunction

  function logic [2:0] predict_free(logic [31:0] a, logic [31:0] n);
    logic [31:0] s, l;
    if (n == 0) return ST_ZERO;
    if (a < base_r || 33'(a) + n > 33'(top_r)) return ST_OK;
    if (!insert_extent(a, n)) return ST_FULL;
    s = ext_start[ext_cnt-1];
    l = ext_len[ext_cnt-1];
    // A free tail at the heap top goes back; at the heap base it is only trimmed.
    if (33'(s) + l == 33'(top_r) && l >= give_r) begin
      if (s == base_r) begin
        if (l > give_r) begin
          ext_len[ext_cnt-1] = give_r;
          top_r = s + give_r;
        end
      end else begin
        drop_extent(ext_cnt - 1);
        top_r = s;
      end
    end
    return ST_OK;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: response %s is 0x%08h, expected 0x%08h", $realtime, field, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g, w;
    if (!rst_ni) begin
      base_r   = 32'd0;
      limit_r  = RST_HEAP_LIMIT;
      page_r   = RST_PAGE_BYTES;
      grow_r   = RST_GROW_MIN;
      give_r   = RST_GIVE_BACK;
      minblk_r = RST_MIN_BLOCK;
      large_r  = RST_LARGE_THR;
      ext_cnt  = 0;
      top_r    = 32'd0;
      grant_q.delete();
      fails    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_HEAP_BASE: begin
            base_r  = cfg_data_i;
            ext_cnt = 0;
            top_r   = cfg_data_i;
          end
          REG_HEAP_LIMIT:      limit_r  = cfg_data_i;
          REG_PAGE_BYTES:      page_r   = cfg_data_i[16:0];
          REG_GROW_MIN:        grow_r   = cfg_data_i;
          REG_GIVE_BACK:       give_r   = cfg_data_i;
          REG_MIN_BLOCK:       minblk_r = cfg_data_i[12:0];
          REG_LARGE_THRESHOLD: large_r  = cfg_data_i;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_ALLOC) begin
          predict_alloc(req.req_size, g);
        end else begin
          g = '{predict_free(req.free_address, req.free_length), 32'd0, 32'd0, 32'd0};
        end
        if (g.status != ST_OK) begin
          g.addr = 32'd0;
          g.len  = 32'd0;
        end
        g.top = top_r;
        grant_q.push_back(g);
      end
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: response with no request outstanding", $realtime);
          fails++;
        end else begin
          w = grant_q.pop_front();
          if (rsp.status !== w.status) report("status", 32'(rsp.status), 32'(w.status));
          if (rsp.grant_address !== w.addr) report("grant_address", rsp.grant_address, w.addr);
          if (rsp.grant_length !== w.len) report("grant_length", rsp.grant_length, w.len);
          if (rsp.heap_end_now !== w.top) report("heap_end_now", rsp.heap_end_now, w.top);
        end
      end
    end
  end

endmodule

/* test/first_fit_extent_allocator_tb.sv */
// Top of the allocator testbench: clock, reset, register phases, request stimulus
// and response back-pressure. Needs ffea_pkg, ffea_if, the block and its checker.
module first_fit_extent_allocator_tb;
  import ffea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i = REG_HEAP_BASE;
  logic [31:0]       cfg_data_i = 32'd0;
  int                fail_count, pending;
  int                sent = 0;
  bit                quiet = 0;
  bit                held = 0;
  logic [31:0]       live_addr[$];
  logic [31:0]       live_len[$];

  ffea_req_if req_ch ();
  ffea_rsp_if rsp_ch ();

  first_fit_extent_allocator dut (
    .clk_i, .rst_ni, .req(req_ch), .rsp(rsp_ch), .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  first_fit_extent_allocator_checker chk (
    .clk_i, .rst_ni, .req(req_ch), .rsp(rsp_ch), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Blocks granted so far, kept so that frees can hand them back.
  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK && rsp_ch.grant_length != 0) begin
      live_addr.push_back(rsp_ch.grant_address);
      live_len.push_back(rsp_ch.grant_length);
    end
  end

  // Response side: random stalls, one long hold-off so the block backs up.
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent >= 300) begin
        held = 1;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic t, logic [31:0] size, logic [31:0] fa, logic [31:0] fl);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= t;
    req_ch.req_size     <= size;
    req_ch.free_address <= fa;
    req_ch.free_length  <= fl;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic free_live();
    int k;
    logic [31:0] a, n;
    k = $urandom_range(0, live_addr.size() - 1);
    a = live_addr[k];
    n = live_len[k];
    live_addr.delete(k);
    live_len.delete(k);
    send(REQ_FREE, $urandom, a, n);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50 || (pick < 88 && live_addr.size() == 0)) begin
      send(REQ_ALLOC, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6000)
                                                   : $urandom_range(1, 200),
           $urandom, $urandom);
    end else if (pick < 88) begin
      free_live();
    end else begin
      case ($urandom_range(0, 3))
        0: send(REQ_ALLOC, 32'd0, $urandom, $urandom);
        1: send(REQ_ALLOC, $urandom, $urandom, $urandom);
        2: send(REQ_FREE, $urandom, $urandom, $urandom);
        default: send(REQ_FREE, $urandom, $urandom, 32'd0);
      endcase
    end
  endtask

  // Waits for all responses and for the block to settle, then writes all registers.
  task automatic load_registers(logic [31:0] v[7]);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IW'(i);
      cfg_data_i  <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    live_addr.delete();
    live_len.delete();
    @(posedge clk_i);
  endtask

  logic [31:0] phase_regs[5][7] = '{
    '{32'h0, 32'h1000_0000, 32'd4096, 32'h0200_0000, 32'h0200_0000, 32'd32, 32'h0010_0000},
    '{32'h1000, 32'h4000, 32'd64, 32'd0, 32'd256, 32'd16, 32'd1024},
    '{32'h8000_0000, 32'h0010_0000, 32'd0, 32'd100, 32'd0, 32'd0, 32'd64},
    '{32'hFFFF_0000, 32'hFFFF_FFFF, 32'h1_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4096,
      32'h8000_0000},
    '{32'hFFFF_F000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'h800, 32'd4096, 32'h0001_0000}
  };
  int phase_items[5] = '{400, 400, 350, 125, 270};

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_ALLOC;
    req_ch.req_size     = 32'd0;
    req_ch.free_address = 32'd0;
    req_ch.free_length  = 32'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero and large sizes, bad frees, then several grants and frees of granted blocks.
    send(REQ_ALLOC, 32'd0, 32'd0, 32'd0);
    send(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(REQ_ALLOC, 32'hFFFF_FFF7, 32'd0, 32'd0);
    send(REQ_ALLOC, 32'd1048568, 32'd0, 32'd0);
    send(REQ_FREE, 32'd0, 32'h100, 32'd0);
    send(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h10);
    send(REQ_FREE, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(REQ_ALLOC, 32'd1, 32'd0, 32'd0);
    send(REQ_ALLOC, 32'd24, 32'd0, 32'd0);
    send(REQ_ALLOC, 32'd25, 32'd0, 32'd0);
    send(REQ_ALLOC, 32'd1048567, 32'd0, 32'd0);
    send(REQ_ALLOC, 32'd524280, 32'd0, 32'd0);
    send(REQ_FREE, 32'd0, 32'h20, 32'h20);
    send(REQ_FREE, 32'd0, 32'h0, 32'h20);
    send(REQ_FREE, 32'd0, 32'h40, 32'h40);

    for (int p = 0; p < 5; p++) begin
      load_registers(phase_regs[p]);
      if (p == 1) begin
        // Fill the table with many small blocks and free every other one.
        for (int i = 0; i < 160; i++) send(REQ_ALLOC, 32'd8, 32'd0, 32'd0);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
        for (int i = 0; i < live_addr.size(); i += 2)
          send(REQ_FREE, 32'd0, live_addr[i], live_len[i]);
        send(REQ_FREE, 32'd0, 32'h1000 + 32'h1000, 32'h10);
      end
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 4 && i == phase_items[p] / 2) quiet = 1;
        random_request();
      end
    end

    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
